[rtl/bdq_pkg.sv]
// Shared types, constants and helpers for the bounded deque with key removal.
// Used by the channel interfaces, the entry memory and the sequencer.
// No dependencies.
`default_nettype none

package bdq_pkg;

  // Storage geometry
  localparam int DEPTH        = 128;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 64;

  // Channel field widths
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int KEY_W = 32;
  localparam int PAY_W = 64;
  localparam int OCC_W = 8;

  // Derived widths: an index into the ring, and a count that can hold DEPTH
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // One write port and one read port per cycle
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

  // Physical slot of a logical position; head and offset stay below 2*DEPTH
  function automatic idx_t slot_addr(idx_t head, cnt_t offs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(offs);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [KEY_BITS-1:0] key_to_store(logic [KEY_W-1:0] k);
    logic [63:0] w;
    w = 64'(k);
    return w[KEY_BITS-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] key_from_store(logic [KEY_BITS-1:0] k);
    logic [63:0] w;
    w = 64'(k);
    return w[KEY_W-1:0];
  endfunction

  function automatic logic [PAYLOAD_BITS-1:0] pay_to_store(logic [PAY_W-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[PAYLOAD_BITS-1:0];
  endfunction

  function automatic logic [PAY_W-1:0] pay_from_store(logic [PAYLOAD_BITS-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[PAY_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] occ_of(cnt_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[OCC_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/bdq_if.sv]
// Request and response channel interfaces: valid/ready plus payload.
// Depends on bdq_pkg for field widths.
`default_nettype none

interface bdq_req_if import bdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] entry_key;
  logic [PAY_W-1:0] entry_payload;

  modport source (output valid, op, entry_key, entry_payload, input ready);
  modport sink   (input valid, op, entry_key, entry_payload, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, out_key, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_key, out_payload, occupancy, output ready);
endinterface

`default_nettype wire

[rtl/bounded_deque_with_key_removal_top.sv]
// Top level of the bounded deque with key removal.
// Depends on bdq_pkg, bdq_if, bdq_mem and bdq_seq.
//
//  channel | dir | fields
//  --------+-----+--------------------------------------------------
//  req_i   | in  | op, entry_key, entry_payload
//  rsp_o   | out | status, out_key, out_payload, occupancy
//
// Append, insert and every rejected request are answered from the idle state;
// pop first reads the head entry and answers from S_POP. Remove by key uses the
// single read port of the entry store to visit one entry per cycle, first comparing
// keys and then moving the entries behind the match one place toward the head.
// Reset empties the queue at once; the store itself is not cleared.
// A response waits in its output register until taken; a new request is taken
// in the same cycle the previous response is.
`default_nettype none

module bounded_deque_with_key_removal_top import bdq_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);

  mem_req_t mem_req;
  entry_t   mem_rdata;

  bdq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  bdq_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

endmodule

`default_nettype wire

[rtl/bdq_mem.sv]
// Entry store: DEPTH entries, one write and one registered read per cycle.
// Depends on bdq_pkg for entry_t and mem_req_t.
`default_nettype none

module bdq_mem import bdq_pkg::*; (
  input  wire      clk_i,
  input  mem_req_t mem_req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // Write and read the store; contents are undefined until written
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/bdq_seq.sv]
// Sequencer: ring pointers, key compare unit, shift sweep and response register.
// Depends on bdq_pkg and the bdq_req_if / bdq_rsp_if interfaces.
`default_nettype none

module bdq_seq import bdq_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  bdq_req_if.sink     req,
  bdq_rsp_if.source   rsp,
  output mem_req_t    mem_req_o,
  input  entry_t      mem_rdata_i
);

  state_e  state_q, state_d;
  idx_t    head_q, head_d;
  cnt_t    count_q, count_d;
  idx_t    idx_q, idx_d;
  logic    out_valid_q, out_valid_d;

  logic [KEY_BITS-1:0] key_q, key_d;
  entry_t              out_q, out_d;
  status_e             status_q, status_d;
  logic [OCC_W-1:0]    occ_q, occ_d;

  logic    accept;
  logic    full;
  logic    empty;
  logic    hit;
  logic    last_scan;
  logic    more_shift;
  op_e     op_in;
  cnt_t    idx_cnt;
  cnt_t    count_inc;
  cnt_t    count_dec;
  idx_t    head_prev;

  // Handshake and status flags
  assign req.ready  = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign op_in      = op_e'(req.op);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign idx_cnt    = CNT_W'(idx_q);
  assign count_inc  = count_q + CNT_W'(1);
  assign count_dec  = count_q - CNT_W'(1);
  assign head_prev  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);

  // Compare unit: entry just read against the search key
  assign hit        = (mem_rdata_i.key == key_q);
  assign last_scan  = ((idx_cnt + CNT_W'(1)) == count_q);
  assign more_shift = (((CNT_W+1)'(idx_q) + (CNT_W+1)'(2)) < (CNT_W+1)'(count_q));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_POP:    state_d = empty ? S_IDLE : S_POP;
            OP_REMOVE: state_d = empty ? S_IDLE : S_SCAN;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        state_d = S_IDLE;
      end
      S_SCAN: begin
        priority if (hit) begin
          state_d = last_scan ? S_IDLE : S_SHIFT;
        end else if (last_scan) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SHIFT: begin
        state_d = more_shift ? S_SHIFT : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory requests and response register
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    key_d       = key_q;
    out_d       = out_q;
    status_d    = status_q;
    occ_d       = occ_q;
    out_valid_d = out_valid_q && !rsp.ready;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = head_q;
    mem_req_o.wdata = mem_rdata_i;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = key_to_store(req.entry_key);
          unique case (op_in)
            OP_APPEND: begin
              out_valid_d = 1'b1;
              out_d       = '0;
              if (full) begin
                status_d = ST_FULL;
                occ_d    = occ_of(count_q);
              end else begin
                mem_req_o.we            = 1'b1;
                mem_req_o.waddr         = slot_addr(head_q, count_q);
                mem_req_o.wdata.key     = key_to_store(req.entry_key);
                mem_req_o.wdata.payload = pay_to_store(req.entry_payload);
                count_d                 = count_inc;
                status_d                = ST_OK;
                occ_d                   = occ_of(count_inc);
              end
            end
            OP_INSERT: begin
              out_valid_d = 1'b1;
              out_d       = '0;
              if (full) begin
                status_d = ST_FULL;
                occ_d    = occ_of(count_q);
              end else begin
                mem_req_o.we            = 1'b1;
                mem_req_o.waddr         = head_prev;
                mem_req_o.wdata.key     = key_to_store(req.entry_key);
                mem_req_o.wdata.payload = pay_to_store(req.entry_payload);
                head_d                  = head_prev;
                count_d                 = count_inc;
                status_d                = ST_OK;
                occ_d                   = occ_of(count_inc);
              end
            end
            OP_POP: begin
              if (empty) begin
                out_valid_d = 1'b1;
                out_d       = '0;
                status_d    = ST_EMPTY;
                occ_d       = occ_of(count_q);
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = head_q;
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                out_valid_d = 1'b1;
                out_d       = '0;
                status_d    = ST_NOTFOUND;
                occ_d       = occ_of(count_q);
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = head_q;
                idx_d           = '0;
              end
            end
            default: ;
          endcase
        end
      end

      // Hand back the head entry and advance the head
      S_POP: begin
        out_valid_d = 1'b1;
        out_d       = mem_rdata_i;
        status_d    = ST_OK;
        occ_d       = occ_of(count_dec);
        head_d      = slot_addr(head_q, CNT_W'(1));
        count_d     = count_dec;
      end

      // Compare one entry per cycle while the next one is read
      S_SCAN: begin
        priority if (hit) begin
          out_d = mem_rdata_i;
          if (last_scan) begin
            out_valid_d = 1'b1;
            status_d    = ST_OK;
            occ_d       = occ_of(count_dec);
            count_d     = count_dec;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = slot_addr(head_q, idx_cnt + CNT_W'(1));
          end
        end else if (last_scan) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          status_d    = ST_NOTFOUND;
          occ_d       = occ_of(count_q);
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = slot_addr(head_q, idx_cnt + CNT_W'(1));
          idx_d           = idx_q + IDX_W'(1);
        end
      end

      // Close the gap: write entry idx+1 into idx, read idx+2
      S_SHIFT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = slot_addr(head_q, idx_cnt);
        mem_req_o.wdata = mem_rdata_i;
        if (more_shift) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = slot_addr(head_q, idx_cnt + CNT_W'(2));
          idx_d           = idx_q + IDX_W'(1);
        end else begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          occ_d       = occ_of(count_dec);
          count_d     = count_dec;
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    out_q    <= out_d;
    status_q <= status_d;
    occ_q    <= occ_d;
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = status_q;
  assign rsp.out_key     = key_from_store(out_q.key);
  assign rsp.out_payload = pay_from_store(out_q.payload);
  assign rsp.occupancy   = occ_q;

endmodule

`default_nettype wire
